### sv/obl_pkg.sv
`default_nettype none
package obl_pkg;

    localparam int CAPACITY = 16;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        FN_PUSH_FRONT  = 3'd0,
        FN_PUSH_BACK   = 3'd1,
        FN_INS_AFTER   = 3'd2,
        FN_INS_BEFORE  = 3'd3,
        FN_POP_FRONT   = 3'd4,
        FN_POP_BACK    = 3'd5,
        FN_DELETE      = 3'd6,
        FN_READ_ALL    = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // one access request to the entry store, indexes are list positions
    typedef struct packed {
        logic          rd_en;
        logic [CW-1:0] rd_idx;
        logic          wr_en;
        logic [CW-1:0] wr_idx;
        logic [7:0]    wr_data;
    } t_ram_req;

endpackage
`default_nettype wire

### sv/obl_if.sv
`default_nettype none
interface obl_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] value;
    logic [7:0] key;
    modport source (output valid, output func, output value, output key, input ready);
    modport sink (input valid, input func, input value, input key, output ready);
endinterface

interface obl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data;
    logic [4:0] count;
    logic       last;
    modport source (output valid, output status, output data, output count, output last,
                    input ready);
    modport sink (input valid, input status, input data, input count, input last,
                  output ready);
endinterface
`default_nettype wire

### sv/obl_ring.sv
`default_nettype none
module obl_ring (
    input  wire logic                     i_clk,
    input  wire logic [obl_pkg::AW-1:0]   i_head,
    input  wire obl_pkg::t_ram_req        i_req,
    output logic [7:0]                    o_rdata
);

    logic [7:0] r_mem [obl_pkg::CAPACITY];

    // map a list position onto the ring, front entry at the head
    function automatic logic [obl_pkg::AW-1:0] phys(input logic [obl_pkg::AW-1:0] h,
                                                    input logic [obl_pkg::CW-1:0] i);
        logic [obl_pkg::CW:0] s;
        s = {{(obl_pkg::CW + 1 - obl_pkg::AW){1'b0}}, h} + {1'b0, i};
        if (s >= (obl_pkg::CW + 1)'(obl_pkg::CAPACITY)) begin
            s = s - (obl_pkg::CW + 1)'(obl_pkg::CAPACITY);
        end
        return s[obl_pkg::AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[phys(i_head, i_req.wr_idx)] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            o_rdata <= r_mem[phys(i_head, i_req.rd_idx)];
        end
    end

endmodule
`default_nettype wire

### sv/ordered_byte_list_engine_core.sv
`default_nettype none
// Channel  | Dir | Payload                          | Beat taken when
// i_in     | in  | func[2:0] value[7:0] key[7:0]    | valid && ready
// o_out    | out | status[1:0] data[7:0] count[4:0] last | valid && ready
//
// One command at a time. Push: write, emit. Pop: read, take data, emit.
// Insert/delete: a key scan (read, compare) per entry visited, then each
// shifted entry goes through the entry store (read, then write back). Read
// all: a read and an emit per entry. Reset (synchronous, active low) empties
// the list; no clearing pass, entries are only read below the count. A
// stalled result beat holds in the output register and stalls the sequencer.
module ordered_byte_list_engine_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    obl_in_if.sink     i_in,
    obl_out_if.source  o_out
);

    localparam int CW = obl_pkg::CW;
    localparam int AW = obl_pkg::AW;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_POP_DATA, S_SCAN_RD, S_SCAN_CMP,
        S_SH_RD, S_SH_WR, S_PLACE, S_RD_REQ, S_RD_EMIT, S_EMIT
    } t_state;

    t_state            r_state;
    obl_pkg::t_func    r_func;
    logic [7:0]        r_value;
    logic [7:0]        r_key;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_head;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_tgt;
    obl_pkg::t_status  r_st;
    logic [7:0]        r_dat;

    logic              r_ov;
    logic [1:0]        r_o_status;
    logic [7:0]        r_o_data;
    logic [4:0]        r_o_count;
    logic              r_o_last;

    obl_pkg::t_ram_req ram_req;
    logic [7:0]        rdata;
    logic              can_emit;
    logic              is_full;
    logic              is_empty;
    logic [CW:0]       n_idx;

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ov;
    assign o_out.status = r_o_status;
    assign o_out.data   = r_o_data;
    assign o_out.count  = r_o_count;
    assign o_out.last   = r_o_last;

    assign can_emit = !r_ov || o_out.ready;
    assign is_full  = (r_count == CW'(obl_pkg::CAPACITY));
    assign is_empty = (r_count == '0);

    obl_ring u_ring (
        .i_clk   (i_clk),
        .i_head  (r_head),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    // store requests follow the sequencer state
    always_comb begin
        ram_req = '0;
        unique case (r_state)
            S_EXEC: begin
                unique case (r_func)
                    obl_pkg::FN_PUSH_FRONT: begin
                        // position one below the front wraps to the new head
                        ram_req.wr_en   = !is_full;
                        ram_req.wr_idx  = CW'(obl_pkg::CAPACITY - 1);
                        ram_req.wr_data = r_value;
                    end
                    obl_pkg::FN_PUSH_BACK: begin
                        ram_req.wr_en   = !is_full;
                        ram_req.wr_idx  = r_count;
                        ram_req.wr_data = r_value;
                    end
                    obl_pkg::FN_POP_FRONT: begin
                        ram_req.rd_en  = !is_empty;
                        ram_req.rd_idx = '0;
                    end
                    obl_pkg::FN_POP_BACK: begin
                        ram_req.rd_en  = !is_empty;
                        ram_req.rd_idx = r_count - CW'(1);
                    end
                    default: ;
                endcase
            end
            S_SCAN_RD, S_RD_REQ: begin
                ram_req.rd_en  = 1'b1;
                ram_req.rd_idx = r_idx;
            end
            S_SH_RD: begin
                ram_req.rd_en  = 1'b1;
                ram_req.rd_idx = (r_func == obl_pkg::FN_DELETE) ? r_idx + CW'(1)
                                                               : r_idx - CW'(1);
            end
            S_SH_WR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_idx  = r_idx;
                ram_req.wr_data = rdata;
            end
            S_PLACE: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_idx  = r_idx;
                ram_req.wr_data = r_value;
            end
            default: ;
        endcase
    end

    assign n_idx = {1'b0, r_idx} + (CW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // drop the output beat once taken; a new load below overrides
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func  <= obl_pkg::t_func'(i_in.func);
                        r_value <= i_in.value;
                        r_key   <= i_in.key;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_dat <= '0;
                    r_idx <= '0;
                    unique case (r_func)
                        obl_pkg::FN_PUSH_FRONT, obl_pkg::FN_PUSH_BACK: begin
                            r_state <= S_EMIT;
                            if (is_full) begin
                                r_st <= obl_pkg::ST_FULL;
                            end else begin
                                r_st    <= obl_pkg::ST_OK;
                                r_count <= r_count + CW'(1);
                                if (r_func == obl_pkg::FN_PUSH_FRONT) begin
                                    r_head <= (r_head == '0) ? AW'(obl_pkg::CAPACITY - 1)
                                                             : r_head - AW'(1);
                                end
                            end
                        end
                        obl_pkg::FN_INS_AFTER, obl_pkg::FN_INS_BEFORE: begin
                            if (is_empty) begin
                                r_st    <= obl_pkg::ST_EMPTY;
                                r_state <= S_EMIT;
                            end else if (is_full) begin
                                r_st    <= obl_pkg::ST_FULL;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end
                        obl_pkg::FN_POP_FRONT, obl_pkg::FN_POP_BACK: begin
                            if (is_empty) begin
                                r_st    <= obl_pkg::ST_EMPTY;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_POP_DATA;
                            end
                        end
                        obl_pkg::FN_DELETE: begin
                            if (is_empty) begin
                                r_st    <= obl_pkg::ST_EMPTY;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end
                        obl_pkg::FN_READ_ALL: begin
                            if (is_empty) begin
                                r_st    <= obl_pkg::ST_EMPTY;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_RD_REQ;
                            end
                        end
                    endcase
                end
                S_POP_DATA: begin
                    // read data of the end entry is back
                    r_dat   <= rdata;
                    r_st    <= obl_pkg::ST_OK;
                    r_count <= r_count - CW'(1);
                    if (r_func == obl_pkg::FN_POP_FRONT) begin
                        r_head <= (r_head == AW'(obl_pkg::CAPACITY - 1)) ? '0
                                                                         : r_head + AW'(1);
                    end
                    r_state <= S_EMIT;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (rdata == r_key) begin
                        if (r_func == obl_pkg::FN_DELETE) begin
                            r_dat <= r_key;
                            r_st  <= obl_pkg::ST_OK;
                            if (n_idx < {1'b0, r_count}) begin
                                r_state <= S_SH_RD;
                            end else begin
                                r_count <= r_count - CW'(1);
                                r_state <= S_EMIT;
                            end
                        end else begin
                            // open a gap at the target, shifting from the back
                            r_tgt <= (r_func == obl_pkg::FN_INS_AFTER) ? n_idx[CW-1:0] : r_idx;
                            r_idx <= r_count;
                            if (((r_func == obl_pkg::FN_INS_AFTER) ? n_idx : {1'b0, r_idx})
                                < {1'b0, r_count}) begin
                                r_state <= S_SH_RD;
                            end else begin
                                r_state <= S_PLACE;
                            end
                        end
                    end else if (n_idx == {1'b0, r_count}) begin
                        r_st    <= obl_pkg::ST_NOTFOUND;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx   <= n_idx[CW-1:0];
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (r_func == obl_pkg::FN_DELETE) begin
                        r_idx <= n_idx[CW-1:0];
                        if (n_idx + (CW + 1)'(1) < {1'b0, r_count}) begin
                            r_state <= S_SH_RD;
                        end else begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_idx   <= r_idx - CW'(1);
                        r_state <= (r_idx - CW'(1) > r_tgt) ? S_SH_RD : S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_st    <= obl_pkg::ST_OK;
                    r_dat   <= '0;
                    r_count <= r_count + CW'(1);
                    r_state <= S_EMIT;
                end
                S_RD_REQ: begin
                    r_state <= S_RD_EMIT;
                end
                S_RD_EMIT: begin
                    // store read data holds until the next read is issued
                    if (can_emit) begin
                        r_ov       <= 1'b1;
                        r_o_status <= obl_pkg::ST_OK;
                        r_o_data   <= rdata;
                        r_o_count  <= 5'(r_count);
                        r_o_last   <= (n_idx == {1'b0, r_count});
                        r_idx      <= n_idx[CW-1:0];
                        r_state    <= (n_idx == {1'b0, r_count}) ? S_IDLE : S_RD_REQ;
                    end
                end
                S_EMIT: begin
                    if (can_emit) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_st;
                        r_o_data   <= r_dat;
                        r_o_count  <= 5'(r_count);
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/obl_checker.sv
`default_nettype none
module obl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_out_status,
    input wire logic [7:0] i_out_data,
    input wire logic [4:0] i_out_count,
    input wire logic       i_out_last
);

    // failed operations give a single beat
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != obl_pkg::ST_OK) |-> i_out_last)
        else $error("error status without last");

    a_fail_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != obl_pkg::ST_OK) |-> (i_out_data == 8'd0))
        else $error("error status with nonzero data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == obl_pkg::ST_EMPTY) |-> (i_out_count == 5'd0))
        else $error("empty status with nonzero count");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command taken while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled beat changed");

endmodule

bind ordered_byte_list_engine_core obl_checker u_obl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_data   (o_out.data),
    .i_out_count  (o_out.count),
    .i_out_last   (o_out.last)
);
`default_nettype wire
